// ----- src/ilfl_pkg.sv -----
// ----------------------------------------------------------------------------
// ilfl_pkg
// Types, constants and codes shared by the indexed free-list manager.
// ----------------------------------------------------------------------------
`default_nettype none

package ilfl_pkg;

  // Table geometry.
  localparam int MAX_ENTRIES = 1024;
  localparam int IW = $clog2(MAX_ENTRIES);      // entry address width
  localparam int VW = $clog2(MAX_ENTRIES + 1);  // link value width (holds the marker)

  // Configuration register.
  localparam int CW        = 11;
  localparam int CFG_RESET = 1024;
  localparam int HEAD_RESET_INT = (CFG_RESET == 0) ? 1 :
                                  (CFG_RESET > MAX_ENTRIES) ? MAX_ENTRIES : CFG_RESET;
  localparam logic [VW-1:0] HEAD_RESET = VW'(HEAD_RESET_INT);

  // Field widths.
  localparam int FW = 2;  // operation code
  localparam int LW = 2;  // list selector
  localparam int EW = 2;  // error code
  localparam int NUM_LISTS = 3;

  // Operation codes.
  localparam logic [FW-1:0] FUNC_POP      = 2'd0;
  localparam logic [FW-1:0] FUNC_PUSH     = 2'd1;
  localparam logic [FW-1:0] FUNC_TRANSFER = 2'd2;
  localparam logic [FW-1:0] FUNC_INIT     = 2'd3;

  // List selectors.
  localparam logic [LW-1:0] LIST_FREE       = 2'd0;
  localparam logic [LW-1:0] LIST_WAITING    = 2'd1;
  localparam logic [LW-1:0] LIST_PROCESSING = 2'd2;

  // Error codes.
  localparam logic [EW-1:0] ERR_OK        = 2'd0;
  localparam logic [EW-1:0] ERR_PUSH_IDX  = 2'd1;
  localparam logic [EW-1:0] ERR_EMPTY_SRC = 2'd2;
  localparam logic [EW-1:0] ERR_BAD_LIST  = 2'd3;

  typedef struct packed {
    logic [FW-1:0] func;
    logic [LW-1:0] list_sel;
    logic [LW-1:0] target_list;
    logic [IW-1:0] entry_index;
  } ilfl_in_t;

  typedef struct packed {
    logic [VW-1:0] popped_index;
    logic          list_was_empty;
    logic [EW-1:0] error_code;
  } ilfl_out_t;

  typedef struct packed {
    logic          we;
    logic [IW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic          re;
    logic [IW-1:0] raddr;
  } ilfl_ram_req_t;

  typedef struct packed {
    logic in_ready;
    logic idle;
  } ilfl_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_INIT
  } state_t;

endpackage

`default_nettype wire

// ----- src/ilfl_ram.sv -----
// ----------------------------------------------------------------------------
// ilfl_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ilfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/ilfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// ilfl_ctrl
// Sequencer for the list operations: holds the three list heads, drives the
// link table and produces one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module ilfl_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [ilfl_pkg::VW-1:0]   n,
  input  wire logic                      in_valid,
  input  wire ilfl_pkg::ilfl_in_t        in_item,
  input  wire logic                      slot_free,
  input  wire logic [ilfl_pkg::VW-1:0]   rdata,
  output ilfl_pkg::ilfl_ram_req_t        ram_req,
  output ilfl_pkg::ilfl_stat_t           stat,
  output logic                           res_valid,
  output ilfl_pkg::ilfl_out_t            res
);

  localparam int VW = ilfl_pkg::VW;
  localparam int IW = ilfl_pkg::IW;
  localparam int LW = ilfl_pkg::LW;
  localparam int NL = ilfl_pkg::NUM_LISTS;

  ilfl_pkg::state_t state, state_next;
  logic [VW-1:0] heads      [NL];
  logic [VW-1:0] heads_next [NL];
  logic [VW-1:0] cnt, cnt_next;
  logic [IW-1:0] pop_addr, pop_addr_next;
  logic [LW-1:0] pop_sel, pop_sel_next;

  logic          accept;
  logic          bad_sel;
  logic [VW-1:0] src_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilfl_pkg::S_IDLE;
      for (int k = 0; k < NL; k++) begin
        heads[k] <= ilfl_pkg::HEAD_RESET;
      end
      cnt <= '0;
    end else begin
      state <= state_next;
      for (int k = 0; k < NL; k++) begin
        heads[k] <= heads_next[k];
      end
      cnt <= cnt_next;
    end
    pop_addr <= pop_addr_next;
    pop_sel  <= pop_sel_next;
  end

  assign stat.idle     = (state == ilfl_pkg::S_IDLE);
  assign stat.in_ready = stat.idle && slot_free;
  assign accept        = in_valid && stat.in_ready;

  always_comb begin
    src_head = ilfl_pkg::HEAD_RESET;
    for (int k = 0; k < NL; k++) begin
      if (LW'(k) == in_item.list_sel) begin
        src_head = heads[k];
      end
    end
  end

  assign bad_sel = (in_item.list_sel > ilfl_pkg::LIST_PROCESSING) ||
                   ((in_item.func == ilfl_pkg::FUNC_TRANSFER) &&
                    (in_item.target_list > ilfl_pkg::LIST_PROCESSING));

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    pop_addr_next = pop_addr;
    pop_sel_next  = pop_sel;
    for (int k = 0; k < NL; k++) begin
      heads_next[k] = heads[k];
    end
    ram_req   = '0;
    res_valid = 1'b0;
    res       = '0;

    case (state)
      ilfl_pkg::S_IDLE: begin
        if (accept) begin
          if (in_item.func == ilfl_pkg::FUNC_INIT) begin
            cnt_next   = '0;
            state_next = ilfl_pkg::S_INIT;
          end else if (bad_sel) begin
            res_valid      = 1'b1;
            res.error_code = ilfl_pkg::ERR_BAD_LIST;
          end else begin
            case (in_item.func)
              ilfl_pkg::FUNC_POP: begin
                if (src_head >= n) begin
                  res_valid          = 1'b1;
                  res.popped_index   = n;
                  res.list_was_empty = 1'b1;
                end else begin
                  // Fetch the link of the head; the head moves in S_POP once the output slot is free.
                  ram_req.re    = 1'b1;
                  ram_req.raddr = src_head[IW-1:0];
                  pop_addr_next = src_head[IW-1:0];
                  pop_sel_next  = in_item.list_sel;
                  state_next    = ilfl_pkg::S_POP;
                end
              end
              ilfl_pkg::FUNC_PUSH: begin
                res_valid = 1'b1;
                if (VW'(in_item.entry_index) >= n) begin
                  res.error_code = ilfl_pkg::ERR_PUSH_IDX;
                end else begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = in_item.entry_index;
                  ram_req.wdata = src_head;
                  for (int k = 0; k < NL; k++) begin
                    if (LW'(k) == in_item.list_sel) begin
                      heads_next[k] = VW'(in_item.entry_index);
                    end
                  end
                end
              end
              default: begin
                res_valid = 1'b1;
                if (src_head >= n) begin
                  res.error_code = ilfl_pkg::ERR_EMPTY_SRC;
                end else begin
                  // Source is cleared after the target is set, so a move onto
                  // itself leaves the list empty.
                  for (int k = 0; k < NL; k++) begin
                    if (LW'(k) == in_item.target_list) begin
                      heads_next[k] = src_head;
                    end
                  end
                  for (int k = 0; k < NL; k++) begin
                    if (LW'(k) == in_item.list_sel) begin
                      heads_next[k] = n;
                    end
                  end
                end
              end
            endcase
          end
        end
      end

      ilfl_pkg::S_POP: begin
        if (slot_free) begin
          for (int k = 0; k < NL; k++) begin
            if (LW'(k) == pop_sel) begin
              heads_next[k] = rdata;
            end
          end
          ram_req.we       = 1'b1;
          ram_req.waddr    = pop_addr;
          ram_req.wdata    = n;
          res_valid        = 1'b1;
          res.popped_index = VW'(pop_addr);
          state_next       = ilfl_pkg::S_IDLE;
        end
      end

      ilfl_pkg::S_INIT: begin
        if (cnt < n) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = cnt[IW-1:0];
          ram_req.wdata = cnt + VW'(1);
          cnt_next      = cnt + VW'(1);
        end else if (slot_free) begin
          heads_next[ilfl_pkg::LIST_FREE]       = '0;
          heads_next[ilfl_pkg::LIST_WAITING]    = n;
          heads_next[ilfl_pkg::LIST_PROCESSING] = n;
          res_valid  = 1'b1;
          state_next = ilfl_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ilfl_pkg::S_IDLE;
      end
    endcase
  end

  a_ram_one_access: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.we && ram_req.re))
    else $error("table read and write in the same cycle");

  a_res_has_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> slot_free)
    else $error("result produced while output slot is occupied");

  a_read_then_pop: assert property (@(posedge clk) disable iff (rst)
    ram_req.re |=> (state == ilfl_pkg::S_POP))
    else $error("table read issued outside a pop");

  a_init_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ilfl_pkg::S_INIT) |-> (cnt <= n))
    else $error("init sweep ran past the entry count");

endmodule

`default_nettype wire

// ----- src/indexed_list_free_list_manager.sv -----
// ----------------------------------------------------------------------------
// indexed_list_free_list_manager
// Three linked lists (free, waiting, processing) over one link table.
// ----------------------------------------------------------------------------
// Items arrive on in_valid/in_stall/in_data and each one gives exactly one
// result on out_valid/out_stall/out_data. A transfer happens on a channel
// when valid is high and stall is low. The block takes one item at a time:
// push, transfer and rejected items finish in the accepting cycle, a pop
// first reads the head's link from the table RAM, whose read is registered,
// and finishes in S_POP, and init steps through the accepting cycle, one
// table write per entry and a closing step that sets the heads, where n is
// entries_in_use limited to 1..MAX_ENTRIES. Results land in an output
// register in the cycle after the item finishes. While that register is held
// by out_stall the block accepts no new item, and a pop or init already
// under way holds its result until the register drains.
// entries_in_use is written through cfg_valid/cfg_ready while the block is
// idle. Reset sets the register to 1024, empties all three lists and clears
// out_valid; the table holds nothing usable until an init.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_free_list_manager (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire ilfl_pkg::ilfl_in_t       in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output ilfl_pkg::ilfl_out_t           out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [ilfl_pkg::CW-1:0]  cfg_data
);

  localparam int VW = ilfl_pkg::VW;

  logic [ilfl_pkg::CW-1:0] entries_in_use;
  logic [VW-1:0]           n;
  logic                    slot_free;
  logic                    res_valid;
  logic [VW-1:0]           rdata;
  ilfl_pkg::ilfl_out_t     res;
  ilfl_pkg::ilfl_ram_req_t ram_req;
  ilfl_pkg::ilfl_stat_t    stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ilfl_pkg::CW'(ilfl_pkg::CFG_RESET);
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use <= cfg_data;
    end
  end

  // End-of-list marker: the register clamped into 1..MAX_ENTRIES.
  always_comb begin
    if (entries_in_use == '0) begin
      n = VW'(1);
    end else if (int'(entries_in_use) > ilfl_pkg::MAX_ENTRIES) begin
      n = VW'(ilfl_pkg::MAX_ENTRIES);
    end else begin
      n = VW'(entries_in_use);
    end
  end

  assign slot_free = !out_valid || !out_stall;

  assign in_stall  = !stat.in_ready;
  assign cfg_ready = stat.idle;

  ilfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .n         (n),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .slot_free (slot_free),
    .rdata     (rdata),
    .ram_req   (ram_req),
    .stat      (stat),
    .res_valid (res_valid),
    .res       (res)
  );

  ilfl_ram #(
    .WIDTH (VW),
    .DEPTH (ilfl_pkg::MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res_valid;
    end
    if (slot_free && res_valid) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire
